// File: src/rfrs_pkg.sv
// Shared widths, codes, command and status types and saturation helpers for the root stepper.
package rfrs_pkg;

  localparam int VW = 32;             // value width, signed fixed point
  localparam int FB = 16;             // fraction bits
  localparam int DW = VW + 1;         // width of a difference of two values
  localparam int PW = 2 * VW + 1;     // width of a product magnitude
  localparam int QW = VW + 3;         // quotient bits; larger quotients are clipped
  localparam int SW = 2 * VW + 4;     // width used for saturating results
  localparam int TW = 31;             // tolerance register width
  localparam int CNTW = 8;            // iteration counter width

  typedef logic signed [VW-1:0] val_t;

  // Datapath operations.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_SAMPLE    = 4'd2;
  localparam logic [3:0] OP_SEC_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV_SEC   = 4'd4;
  localparam logic [3:0] OP_SEC_FIN   = 4'd5;
  localparam logic [3:0] OP_SWAP      = 4'd6;
  localparam logic [3:0] OP_DIV_PHIS  = 4'd7;
  localparam logic [3:0] OP_PHIS_FIN  = 4'd8;
  localparam logic [3:0] OP_DIV_PHIR  = 4'd9;
  localparam logic [3:0] OP_PHIR_FIN  = 4'd10;
  localparam logic [3:0] OP_DIV_RATIO = 4'd11;
  localparam logic [3:0] OP_RATIO_FIN = 4'd12;
  localparam logic [3:0] OP_GAM_MUL   = 4'd13;
  localparam logic [3:0] OP_SCALE     = 4'd14;

  // Result outcomes.
  localparam logic [1:0] OC_EVAL  = 2'd0;
  localparam logic [1:0] OC_ROOT  = 2'd1;
  localparam logic [1:0] OC_NOBR  = 2'd2;
  localparam logic [1:0] OC_FAULT = 2'd3;

  // Request kinds.
  localparam logic OPC_START  = 1'b0;
  localparam logic OPC_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_TOL_X = 2'd0;
  localparam logic [1:0] REG_TOL_Y = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic       inc;
    logic       emit;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic nobr;
    logic e_zero;
    logic ft_small;
    logic ft_opp;
    logic v_zero;
    logic den_zero;
    logic cont;
    logic div_done;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [VW-1:0] vabs(input val_t x);
    vabs = x[VW-1] ? VW'(-x) : VW'(x);
  endfunction

  function automatic val_t sat_val(input logic neg, input logic [SW-1:0] m);
    logic [SW-1:0] lim;
    logic [SW-1:0] c;
    lim = neg ? (SW'(1) << (VW - 1)) : ((SW'(1) << (VW - 1)) - SW'(1));
    c = (m > lim) ? lim : m;
    sat_val = neg ? val_t'(VW'(0) - c[VW-1:0]) : val_t'(c[VW-1:0]);
  endfunction

  function automatic val_t sat_sgn(input logic signed [SW-1:0] x);
    logic [SW-1:0] m;
    m = x[SW-1] ? SW'(-x) : SW'(x);
    sat_sgn = sat_val(x[SW-1], m);
  endfunction

endpackage

// File: src/regula_falsi_root_stepper_top.sv
// Top level of the stepped regula falsi root search: controller, datapath and ports.
// A start request, or a sample whose sign flips the bracket, runs one division; a sample
// that needs the modified step runs four. All divisions run on a shared serial divider at
// one quotient bit per cycle.
// One request is in work at a time; the next is taken from the cycle its result appears.
// Reset is synchronous: the search goes idle and the tolerances and limit return to 66, 66, 100.
module regula_falsi_root_stepper_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // point_a, point_b, value_a, value_b, sample_value
  input  logic [5*rfrs_pkg::VW-1:0]    in_tdata,
  // opcode
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // point, iterations
  output logic [rfrs_pkg::VW+rfrs_pkg::CNTW-1:0] out_tdata,
  // outcome
  output logic [1:0]                   out_tuser,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [rfrs_pkg::TW-1:0]      cfg_wdata
);

  rfrs_pkg::dp_cmd_t  cmd;
  rfrs_pkg::dp_stat_t stat;
  rfrs_pkg::val_t     out_point;
  logic [rfrs_pkg::CNTW-1:0] out_iter;

  rfrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfrs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_code   (out_tuser),
    .out_point  (out_point),
    .out_iter   (out_iter)
  );

  assign out_tdata = {out_iter, out_point};

  // A new result is never written over one still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !stat.out_busy)
    else $error("result written while output register full");

  // The divider is idle whenever the block can take a request.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.div_busy)
    else $error("divider busy while block idle");

  // A missing bracket is always reported with zero iterations.
  a_nobr_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == rfrs_pkg::OC_NOBR) |-> out_iter == '0)
    else $error("no-bracket result with nonzero iterations");

endmodule

// File: src/rfrs_div.sv
// Serial restoring divider giving one quotient bit per cycle, clipped on overflow.
module rfrs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rfrs_pkg::PW-1:0]     num,
  input  logic [rfrs_pkg::DW-1:0]     den,
  output logic                        busy,
  output logic                        done,
  output logic [rfrs_pkg::QW-1:0]     quot
);

  localparam int PW = rfrs_pkg::PW;
  localparam int DW = rfrs_pkg::DW;
  localparam int QW = rfrs_pkg::QW;
  localparam int RW = DW + QW - 1;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [PW-1:0] rem_r;
  logic [RW-1:0] dsh_r;
  logic [QW-1:0] q_r;
  logic          ovf_r;
  logic          ge;
  logic [PW-1:0] rem_diff;

  assign ge       = RW'(rem_r) >= dsh_r;
  assign rem_diff = rem_r - dsh_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(QW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(QW-1){1'b0}}};
      q_r   <= '0;
      // A quotient that needs more than QW bits saturates every result it feeds.
      ovf_r <= (DW + QW)'(num) >= {den, {QW{1'b0}}};
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= rem_diff;
      end
      q_r   <= {q_r[QW-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign busy = cnt_r != '0;
  assign done = done_r;
  assign quot = ovf_r ? {QW{1'b1}} : q_r;

endmodule

// File: src/rfrs_datapath.sv
// Bracket registers, step arithmetic, configuration registers and result register.
module rfrs_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rfrs_pkg::dp_cmd_t              cmd,
  output rfrs_pkg::dp_stat_t             stat,
  input  logic [5*rfrs_pkg::VW-1:0]      in_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [rfrs_pkg::TW-1:0]        cfg_wdata,
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic [1:0]                     out_code,
  output rfrs_pkg::val_t                 out_point,
  output logic [rfrs_pkg::CNTW-1:0]      out_iter
);

  localparam int VW = rfrs_pkg::VW;
  localparam int FB = rfrs_pkg::FB;
  localparam int DW = rfrs_pkg::DW;
  localparam int PW = rfrs_pkg::PW;
  localparam int QW = rfrs_pkg::QW;
  localparam int SW = rfrs_pkg::SW;
  localparam int TW = rfrs_pkg::TW;
  localparam int CNTW = rfrs_pkg::CNTW;
  localparam rfrs_pkg::val_t ONE  = rfrs_pkg::val_t'(1) <<< FB;
  localparam rfrs_pkg::val_t HALF = rfrs_pkg::val_t'(1) <<< (FB - 1);

  rfrs_pkg::val_t lp_r, rp_r, lv_r, rv_r, est_r, ft_r;
  rfrs_pkg::val_t phis_r, den_r, gamma_r;
  logic [CNTW-1:0] cnt_r;
  logic [PW-1:0]   prod_r;
  logic            sgn_r;
  logic [DW-1:0]   dden_r;
  logic [TW-1:0]   tol_x_r, tol_y_r;
  logic [CNTW-1:0] limit_r;
  logic            out_valid_r;
  logic [1:0]      out_code_r;
  rfrs_pkg::val_t  out_point_r;
  logic [CNTW-1:0] out_iter_r;

  logic signed [DW-1:0] d, e;
  logic [DW-1:0]        d_mag, e_mag;
  logic [VW-1:0]        rv_mag, lv_mag, ft_mag;
  logic signed [SW-1:0] sec_sum, ed, den_sum, gam_sum;
  logic [SW-1:0]        ed_mag;
  rfrs_pkg::val_t       phir, ratio, gam;
  logic                 div_start, div_busy, div_done;
  logic [PW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  logic [QW-1:0]        quot;

  assign d      = DW'(rp_r) - DW'(lp_r);
  assign e      = DW'(rv_r) - DW'(lv_r);
  assign d_mag  = d[DW-1] ? DW'(-d) : DW'(d);
  assign e_mag  = e[DW-1] ? DW'(-e) : DW'(e);
  assign rv_mag = rfrs_pkg::vabs(rv_r);
  assign lv_mag = rfrs_pkg::vabs(lv_r);
  assign ft_mag = rfrs_pkg::vabs(ft_r);

  // The secant point is right_point minus the signed quotient.
  assign sec_sum = sgn_r ? (SW'(rp_r) + SW'(quot)) : (SW'(rp_r) - SW'(quot));
  assign ed      = SW'(est_r) - SW'(rp_r);
  assign ed_mag  = ed[SW-1] ? SW'(-ed) : SW'(ed);
  assign phir    = rfrs_pkg::sat_val(ft_r[VW-1] ^ lv_r[VW-1], SW'(quot));
  assign den_sum = SW'(ONE) - SW'(phir);
  assign ratio   = rfrs_pkg::sat_val(phis_r[VW-1] ^ den_r[VW-1], SW'(quot));
  assign gam_sum = SW'(ONE) - SW'(ratio);
  assign gam     = rfrs_pkg::sat_sgn(gam_sum);

  always_comb begin
    div_start = 1'b1;
    div_num   = prod_r;
    div_den   = dden_r;
    unique case (cmd.op)
      rfrs_pkg::OP_DIV_SEC: begin
        div_num = prod_r;
        div_den = dden_r;
      end
      rfrs_pkg::OP_DIV_PHIS: begin
        div_num = PW'(ft_mag) << FB;
        div_den = DW'(rv_mag);
      end
      rfrs_pkg::OP_DIV_PHIR: begin
        div_num = PW'(ft_mag) << FB;
        div_den = DW'(lv_mag);
      end
      rfrs_pkg::OP_DIV_RATIO: begin
        div_num = PW'(rfrs_pkg::vabs(phis_r)) << FB;
        div_den = DW'(rfrs_pkg::vabs(den_r));
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rfrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r    <= '0;
      rp_r    <= '0;
      lv_r    <= '0;
      rv_r    <= '0;
      est_r   <= '0;
      cnt_r   <= '0;
      tol_x_r <= TW'(66);
      tol_y_r <= TW'(66);
      limit_r <= CNTW'(100);
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          rfrs_pkg::REG_TOL_X: tol_x_r <= cfg_wdata;
          rfrs_pkg::REG_TOL_Y: tol_y_r <= cfg_wdata;
          rfrs_pkg::REG_LIMIT: limit_r <= cfg_wdata[CNTW-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        rfrs_pkg::OP_LOAD: begin
          lp_r  <= in_data[VW-1:0];
          rp_r  <= in_data[2*VW-1:VW];
          lv_r  <= in_data[3*VW-1:2*VW];
          rv_r  <= in_data[4*VW-1:3*VW];
          cnt_r <= '0;
        end
        rfrs_pkg::OP_SEC_FIN: begin
          est_r <= rfrs_pkg::sat_sgn(sec_sum);
          if (cmd.inc) begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end
        rfrs_pkg::OP_SWAP: begin
          lp_r <= rp_r;
          rp_r <= est_r;
          lv_r <= rv_r;
          rv_r <= ft_r;
        end
        rfrs_pkg::OP_SCALE: begin
          lv_r <= rfrs_pkg::sat_val(lv_r[VW-1], SW'(prod_r >> FB));
          rp_r <= est_r;
          rv_r <= ft_r;
        end
        default: ;
      endcase
    end
  end

  // Scratch registers for the step arithmetic.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rfrs_pkg::OP_SAMPLE:    ft_r <= in_data[5*VW-1:4*VW];
      rfrs_pkg::OP_SEC_MUL: begin
        prod_r <= PW'(rv_mag) * PW'(d_mag);
        sgn_r  <= rv_r[VW-1] ^ d[DW-1] ^ e[DW-1];
        dden_r <= e_mag;
      end
      rfrs_pkg::OP_PHIS_FIN:
        phis_r <= rfrs_pkg::sat_val(ft_r[VW-1] ^ rv_r[VW-1], SW'(quot));
      rfrs_pkg::OP_PHIR_FIN:  den_r <= rfrs_pkg::sat_sgn(den_sum);
      rfrs_pkg::OP_RATIO_FIN: gamma_r <= gam[VW-1] ? HALF : gam;
      rfrs_pkg::OP_GAM_MUL:   prod_r <= PW'(lv_mag) * PW'(gamma_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_code_r <= cmd.code;
      out_iter_r <= (cmd.code == rfrs_pkg::OC_NOBR) ? '0 : cnt_r;
      unique case (cmd.code)
        rfrs_pkg::OC_NOBR:  out_point_r <= -ONE;
        rfrs_pkg::OC_FAULT: out_point_r <= '0;
        default:            out_point_r <= est_r;
      endcase
    end
  end

  always_comb begin
    stat.nobr     = (lv_r > 0 && rv_r > 0) || (lv_r < 0 && rv_r < 0);
    stat.e_zero   = e == '0;
    stat.ft_small = ft_mag <= VW'(tol_y_r);
    stat.ft_opp   = (ft_r < 0 && rv_r > 0) || (ft_r > 0 && rv_r < 0);
    stat.v_zero   = rv_r == '0 || lv_r == '0;
    stat.den_zero = den_r == '0;
    stat.cont     = cnt_r < limit_r && ed_mag > SW'(tol_x_r);
    stat.div_done = div_done;
    stat.div_busy = div_busy;
    stat.out_busy = out_valid_r && !out_tready;
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_point = out_point_r;
  assign out_iter  = out_iter_r;

endmodule

// File: src/rfrs_ctrl.sv
// Controller state machine sequencing the search steps over the datapath.
module rfrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_opcode,
  output logic                in_tready,
  input  rfrs_pkg::dp_stat_t  stat,
  output rfrs_pkg::dp_cmd_t   cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_CHK       = 5'd1;
  localparam logic [4:0] S_SMP       = 5'd2;
  localparam logic [4:0] S_SEC_MUL   = 5'd3;
  localparam logic [4:0] S_SEC_DIV   = 5'd4;
  localparam logic [4:0] S_SEC_WAIT  = 5'd5;
  localparam logic [4:0] S_SEC_FIN   = 5'd6;
  localparam logic [4:0] S_CHECK     = 5'd7;
  localparam logic [4:0] S_PHIS_DIV  = 5'd8;
  localparam logic [4:0] S_PHIS_WAIT = 5'd9;
  localparam logic [4:0] S_PHIS_FIN  = 5'd10;
  localparam logic [4:0] S_PHIR_DIV  = 5'd11;
  localparam logic [4:0] S_PHIR_WAIT = 5'd12;
  localparam logic [4:0] S_PHIR_FIN  = 5'd13;
  localparam logic [4:0] S_RAT_DIV   = 5'd14;
  localparam logic [4:0] S_RAT_WAIT  = 5'd15;
  localparam logic [4:0] S_RAT_FIN   = 5'd16;
  localparam logic [4:0] S_GAM_MUL   = 5'd17;
  localparam logic [4:0] S_SCALE     = 5'd18;
  localparam logic [4:0] S_EMIT      = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic       searching_r, searching_nxt;
  logic       inc_r, inc_nxt;
  logic [1:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      searching_r <= 1'b0;
      inc_r       <= 1'b0;
      code_r      <= rfrs_pkg::OC_EVAL;
    end else begin
      state_r     <= state_nxt;
      searching_r <= searching_nxt;
      inc_r       <= inc_nxt;
      code_r      <= code_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    searching_nxt = searching_r;
    inc_nxt       = inc_r;
    code_nxt      = code_r;
    cmd           = '0;
    cmd.op        = rfrs_pkg::OP_NONE;
    cmd.inc       = inc_r;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_opcode == rfrs_pkg::OPC_START) begin
            cmd.op        = rfrs_pkg::OP_LOAD;
            searching_nxt = 1'b0;
            inc_nxt       = 1'b0;
            state_nxt     = S_CHK;
          end else if (searching_r) begin
            // A sample is taken only while a search is in progress; otherwise it is dropped without a result.
            cmd.op    = rfrs_pkg::OP_SAMPLE;
            state_nxt = S_SMP;
          end
        end
      end
      S_CHK: begin
        if (stat.nobr) begin
          code_nxt  = rfrs_pkg::OC_NOBR;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SEC_MUL;
        end
      end
      S_SMP: begin
        priority if (stat.ft_small) begin
          code_nxt  = rfrs_pkg::OC_ROOT;
          state_nxt = S_EMIT;
        end else if (stat.ft_opp) begin
          cmd.op    = rfrs_pkg::OP_SWAP;
          inc_nxt   = 1'b1;
          state_nxt = S_SEC_MUL;
        end else if (stat.v_zero) begin
          code_nxt  = rfrs_pkg::OC_FAULT;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PHIS_DIV;
        end
      end
      S_SEC_MUL: begin
        if (stat.e_zero) begin
          code_nxt  = rfrs_pkg::OC_FAULT;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = rfrs_pkg::OP_SEC_MUL;
          state_nxt = S_SEC_DIV;
        end
      end
      S_SEC_DIV: begin
        cmd.op    = rfrs_pkg::OP_DIV_SEC;
        state_nxt = S_SEC_WAIT;
      end
      S_SEC_WAIT: if (stat.div_done) state_nxt = S_SEC_FIN;
      S_SEC_FIN: begin
        cmd.op    = rfrs_pkg::OP_SEC_FIN;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        code_nxt  = stat.cont ? rfrs_pkg::OC_EVAL : rfrs_pkg::OC_ROOT;
        state_nxt = S_EMIT;
      end
      S_PHIS_DIV: begin
        cmd.op    = rfrs_pkg::OP_DIV_PHIS;
        state_nxt = S_PHIS_WAIT;
      end
      S_PHIS_WAIT: if (stat.div_done) state_nxt = S_PHIS_FIN;
      S_PHIS_FIN: begin
        cmd.op    = rfrs_pkg::OP_PHIS_FIN;
        state_nxt = S_PHIR_DIV;
      end
      S_PHIR_DIV: begin
        cmd.op    = rfrs_pkg::OP_DIV_PHIR;
        state_nxt = S_PHIR_WAIT;
      end
      S_PHIR_WAIT: if (stat.div_done) state_nxt = S_PHIR_FIN;
      S_PHIR_FIN: begin
        cmd.op    = rfrs_pkg::OP_PHIR_FIN;
        state_nxt = S_RAT_DIV;
      end
      S_RAT_DIV: begin
        if (stat.den_zero) begin
          code_nxt  = rfrs_pkg::OC_FAULT;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = rfrs_pkg::OP_DIV_RATIO;
          state_nxt = S_RAT_WAIT;
        end
      end
      S_RAT_WAIT: if (stat.div_done) state_nxt = S_RAT_FIN;
      S_RAT_FIN: begin
        cmd.op    = rfrs_pkg::OP_RATIO_FIN;
        state_nxt = S_GAM_MUL;
      end
      S_GAM_MUL: begin
        cmd.op    = rfrs_pkg::OP_GAM_MUL;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = rfrs_pkg::OP_SCALE;
        inc_nxt   = 1'b1;
        state_nxt = S_SEC_MUL;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.code      = code_r;
          searching_nxt = code_r == rfrs_pkg::OC_EVAL;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
